// ===== rtl/core/dmgm_pkg.sv =====
// dmgm_pkg: shared types, constants and register codes for the ducking music mixer
// used by the stream interfaces, the gain ramp, the top level and the checker
// no dependencies

package dmgm_pkg;

    // sample and gain widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 25;
    localparam int STEP_W   = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // unity gain in q1.24
    localparam logic [GAIN_W-1:0] GAIN_ONE = 25'd16777216;

    // register reset values
    localparam logic [GAIN_W-1:0] BASE_GAIN_RST    = 25'd4697620;
    localparam logic [GAIN_W-1:0] DUCK_GAIN_RST    = 25'd1342177;
    localparam logic [STEP_W-1:0] ATTACK_STEP_RST  = 16'd2013;
    localparam logic [STEP_W-1:0] RELEASE_STEP_RST = 16'd503;

    // register index codes (byte address / 4)
    typedef enum logic [2:0] {
        REG_MUSIC_ENABLE = 3'd0,
        REG_BASE_GAIN    = 3'd1,
        REG_DUCK_GAIN    = 3'd2,
        REG_ATTACK_STEP  = 3'd3,
        REG_RELEASE_STEP = 3'd4
    } reg_idx_t;

    // music status codes; the unused code behaves as absent
    typedef enum logic [1:0] {
        ST_PRESENT = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_WAITING = 2'd2
    } music_status_t;

    // configuration seen by the gain ramp
    typedef struct packed {
        logic              music_enable;
        logic [GAIN_W-1:0] base_gain;
        logic [GAIN_W-1:0] duck_gain;
        logic [STEP_W-1:0] attack_step;
        logic [STEP_W-1:0] release_step;
    } cfg_t;

endpackage

// ===== rtl/core/dmgm_in_if.sv =====
// dmgm_in_if: input stream channel, one audio sample word per handshake
// depends on dmgm_pkg for field widths

interface dmgm_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [dmgm_pkg::SAMPLE_W-1:0] mix_sample;
    logic signed [dmgm_pkg::SAMPLE_W-1:0] music_sample;
    logic                                duck;
    logic [1:0]                          music_status;
    logic                                last_in_block;

    modport source (
        output valid, mix_sample, music_sample, duck, music_status, last_in_block,
        input  ready
    );

    modport sink (
        input  valid, mix_sample, music_sample, duck, music_status, last_in_block,
        output ready
    );

endinterface

// ===== rtl/core/dmgm_out_if.sv =====
// dmgm_out_if: result stream channel, one mixed sample word per handshake
// depends on dmgm_pkg for field widths

interface dmgm_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [dmgm_pkg::SAMPLE_W-1:0] out_sample;
    logic [dmgm_pkg::GAIN_W-1:0]          gain_now;

    modport source (
        output valid, out_sample, gain_now,
        input  ready
    );

    modport sink (
        input  valid, out_sample, gain_now,
        output ready
    );

endinterface

// ===== rtl/core/dmgm_gain_ramp.sv =====
// dmgm_gain_ramp: music gain state and its per-sample slew toward the target
// depends on dmgm_pkg (cfg_t, music_status_t, gain constants)

module dmgm_gain_ramp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmgm_pkg::cfg_t              cfg,
    input  logic                        step,
    input  logic                        duck,
    input  logic [1:0]                  music_status,
    output logic [dmgm_pkg::GAIN_W-1:0] gain_next
);

    logic [dmgm_pkg::GAIN_W-1:0] gain_reg;
    logic [dmgm_pkg::GAIN_W-1:0] sel_gain;
    logic [dmgm_pkg::GAIN_W-1:0] target;
    logic [dmgm_pkg::GAIN_W:0]   up_sum;
    logic [dmgm_pkg::GAIN_W-1:0] up_gain;
    logic [dmgm_pkg::GAIN_W-1:0] down_diff;
    logic [dmgm_pkg::GAIN_W-1:0] release_ext;
    logic [dmgm_pkg::GAIN_W-1:0] down_gain;
    logic [dmgm_pkg::GAIN_W-1:0] ramp_gain;

    // target: zero when disabled, else duck or base gain clamped to unity
    always_comb
    begin
        sel_gain = duck ? cfg.duck_gain : cfg.base_gain;
        if (!cfg.music_enable)
        begin
            target = '0;
        end
        else if (sel_gain > dmgm_pkg::GAIN_ONE)
        begin
            target = dmgm_pkg::GAIN_ONE;
        end
        else
        begin
            target = sel_gain;
        end
    end

    // rising: add attack step, stop at target
    assign up_sum  = {1'b0, gain_reg} + (dmgm_pkg::GAIN_W+1)'(cfg.attack_step);
    assign up_gain = (up_sum > {1'b0, target}) ? target : up_sum[dmgm_pkg::GAIN_W-1:0];

    // falling: subtract release step, stop at target
    assign down_diff   = gain_reg - target;
    assign release_ext = dmgm_pkg::GAIN_W'(cfg.release_step);
    assign down_gain   = (down_diff > release_ext) ? (gain_reg - release_ext) : target;

    always_comb
    begin
        if (gain_reg < target)
        begin
            ramp_gain = up_gain;
        end
        else if (gain_reg > target)
        begin
            ramp_gain = down_gain;
        end
        else
        begin
            ramp_gain = gain_reg;
        end
    end

    // status selects ramp, hold or clear
    always_comb
    begin
        case (music_status)
            dmgm_pkg::ST_PRESENT: gain_next = ramp_gain;
            dmgm_pkg::ST_WAITING: gain_next = gain_reg;
            default:              gain_next = '0;
        endcase
    end

    // gain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (step)
        begin
            gain_reg <= gain_next;
        end
    end

endmodule

// ===== rtl/core/ducking_music_gain_mixer.sv =====
// the input reg loads at acceptance, then the word passes the gain ramp reg, the product
// reg and the output reg; throughput: one word per cycle while the output is not stalled,
// the gain ramp add-compare loop closes through its gain register
// each stage holds its word while the next is full and stalled, so input stays open while a
// result waits until all four stages hold words; reset (rst_n, async low) clears the
// gain to zero, empties the pipeline and loads the register defaults
// depends on dmgm_pkg, dmgm_in_if, dmgm_out_if, dmgm_gain_ramp

module ducking_music_gain_mixer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmgm_pkg::APB_AW-1:0] paddr,
    input  logic [dmgm_pkg::APB_DW-1:0] pwdata,
    output logic [dmgm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    dmgm_in_if.sink                     in_ch,
    dmgm_out_if.source                  out_ch
);

    // configuration registers
    logic                                   music_enable_reg;
    logic [dmgm_pkg::GAIN_W-1:0]            base_gain_reg;
    logic [dmgm_pkg::GAIN_W-1:0]            duck_gain_reg;
    logic [dmgm_pkg::STEP_W-1:0]            attack_step_reg;
    logic [dmgm_pkg::STEP_W-1:0]            release_step_reg;
    logic                                   cfg_wr;
    dmgm_pkg::reg_idx_t                     reg_idx;
    dmgm_pkg::cfg_t                         cfg;

    // stage 1: input register
    logic                                   s1_valid_reg;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   s1_mix_reg;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   s1_music_reg;
    logic                                   s1_duck_reg;
    logic [1:0]                             s1_status_reg;

    // stage 2: gain after ramp, music magnitude
    logic                                   s2_valid_reg;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   s2_mix_reg;
    logic [dmgm_pkg::SAMPLE_W:0]            s2_mag_reg;
    logic                                   s2_neg_reg;
    logic [dmgm_pkg::GAIN_W-1:0]            s2_gain_reg;
    logic                                   s2_active_reg;

    // stage 3: product
    logic                                   s3_valid_reg;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   s3_mix_reg;
    logic [dmgm_pkg::SAMPLE_W+dmgm_pkg::GAIN_W:0] s3_prod_reg;
    logic                                   s3_neg_reg;
    logic [dmgm_pkg::GAIN_W-1:0]            s3_gain_reg;
    logic                                   s3_active_reg;

    // output register
    logic                                   out_valid_reg;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   out_sample_reg;
    logic [dmgm_pkg::GAIN_W-1:0]            out_gain_reg;

    logic                                   out_free;
    logic                                   s3_free;
    logic                                   s2_free;
    logic                                   s1_free;
    logic                                   s1_step;
    logic [dmgm_pkg::GAIN_W-1:0]            gain_next;
    logic [dmgm_pkg::SAMPLE_W:0]            music_mag;
    logic [dmgm_pkg::SAMPLE_W+dmgm_pkg::GAIN_W:0] prod_rnd;
    logic [dmgm_pkg::SAMPLE_W+1:0]          scaled_mag;
    logic signed [dmgm_pkg::SAMPLE_W+2:0]   scaled;
    logic signed [dmgm_pkg::SAMPLE_W+2:0]   sum_wide;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   sum_sat;
    logic signed [dmgm_pkg::SAMPLE_W-1:0]   out_sample_next;

    // apb write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = dmgm_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_enable_reg <= 1'b0;
            base_gain_reg    <= dmgm_pkg::BASE_GAIN_RST;
            duck_gain_reg    <= dmgm_pkg::DUCK_GAIN_RST;
            attack_step_reg  <= dmgm_pkg::ATTACK_STEP_RST;
            release_step_reg <= dmgm_pkg::RELEASE_STEP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                dmgm_pkg::REG_MUSIC_ENABLE: music_enable_reg <= pwdata[0];
                dmgm_pkg::REG_BASE_GAIN:    base_gain_reg    <= pwdata[dmgm_pkg::GAIN_W-1:0];
                dmgm_pkg::REG_DUCK_GAIN:    duck_gain_reg    <= pwdata[dmgm_pkg::GAIN_W-1:0];
                dmgm_pkg::REG_ATTACK_STEP:  attack_step_reg  <= pwdata[dmgm_pkg::STEP_W-1:0];
                dmgm_pkg::REG_RELEASE_STEP: release_step_reg <= pwdata[dmgm_pkg::STEP_W-1:0];
                default:                    ;
            endcase
        end
    end

    // apb read mux
    always_comb
    begin
        unique case (reg_idx)
            dmgm_pkg::REG_MUSIC_ENABLE: prdata = dmgm_pkg::APB_DW'(music_enable_reg);
            dmgm_pkg::REG_BASE_GAIN:    prdata = dmgm_pkg::APB_DW'(base_gain_reg);
            dmgm_pkg::REG_DUCK_GAIN:    prdata = dmgm_pkg::APB_DW'(duck_gain_reg);
            dmgm_pkg::REG_ATTACK_STEP:  prdata = dmgm_pkg::APB_DW'(attack_step_reg);
            dmgm_pkg::REG_RELEASE_STEP: prdata = dmgm_pkg::APB_DW'(release_step_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.music_enable = music_enable_reg;
    assign cfg.base_gain    = base_gain_reg;
    assign cfg.duck_gain    = duck_gain_reg;
    assign cfg.attack_step  = attack_step_reg;
    assign cfg.release_step = release_step_reg;

    // per-stage flow control: a stage loads when empty or when it drains
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s3_free     = !s3_valid_reg || out_free;
    assign s2_free     = !s2_valid_reg || s3_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign in_ch.ready = s1_free;
    assign s1_step     = s1_valid_reg && s2_free;

    // stage 1 load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_ch.valid)
        begin
            s1_mix_reg    <= in_ch.mix_sample;
            s1_music_reg  <= in_ch.music_sample;
            s1_duck_reg   <= in_ch.duck;
            s1_status_reg <= in_ch.music_status;
        end
    end

    // gain ramp, advances once per word leaving stage 1
    dmgm_gain_ramp u_gain_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (s1_step),
        .duck         (s1_duck_reg),
        .music_status (s1_status_reg),
        .gain_next    (gain_next)
    );

    // music magnitude
    assign music_mag = s1_music_reg[dmgm_pkg::SAMPLE_W-1]
                     ? (~{1'b1, s1_music_reg} + 1'b1)
                     : {1'b0, s1_music_reg};

    // stage 2 load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_step)
        begin
            s2_mix_reg    <= s1_mix_reg;
            s2_mag_reg    <= music_mag;
            s2_neg_reg    <= s1_music_reg[dmgm_pkg::SAMPLE_W-1];
            s2_gain_reg   <= gain_next;
            s2_active_reg <= (s1_status_reg == dmgm_pkg::ST_PRESENT) && (gain_next != '0);
        end
    end

    // stage 3: magnitude times gain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            s3_mix_reg    <= s2_mix_reg;
            s3_prod_reg   <= (dmgm_pkg::SAMPLE_W+dmgm_pkg::GAIN_W+1)'(s2_mag_reg)
                           * (dmgm_pkg::SAMPLE_W+dmgm_pkg::GAIN_W+1)'(s2_gain_reg);
            s3_neg_reg    <= s2_neg_reg;
            s3_gain_reg   <= s2_gain_reg;
            s3_active_reg <= s2_active_reg;
        end
    end

    // round half away from zero, restore sign, add and saturate
    assign prod_rnd   = s3_prod_reg + (dmgm_pkg::SAMPLE_W+dmgm_pkg::GAIN_W+1)'(1 << 23);
    assign scaled_mag = prod_rnd[dmgm_pkg::SAMPLE_W+25:24];
    assign scaled     = s3_neg_reg ? -$signed({1'b0, scaled_mag}) : $signed({1'b0, scaled_mag});
    assign sum_wide   = (dmgm_pkg::SAMPLE_W+3)'(s3_mix_reg) + scaled;

    always_comb
    begin
        if (sum_wide > (dmgm_pkg::SAMPLE_W+3)'(32767))
        begin
            sum_sat = 16'sh7FFF;
        end
        else if (sum_wide < -(dmgm_pkg::SAMPLE_W+3)'(32768))
        begin
            sum_sat = 16'sh8000;
        end
        else
        begin
            sum_sat = sum_wide[dmgm_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_sample_next = s3_active_reg ? sum_sat : s3_mix_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
            out_gain_reg   <= s3_gain_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_sample = out_sample_reg;
    assign out_ch.gain_now   = out_gain_reg;

endmodule

// ===== rtl/core/dmgm_checker.sv =====
// dmgm_checker: port-level assertions for ducking_music_gain_mixer, bound to the top
// depends on dmgm_pkg, dmgm_in_if, dmgm_out_if

module dmgm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    dmgm_in_if.sink    in_ch,
    dmgm_out_if.source out_ch
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pending_reg;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    // words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    // no result word without an accepted input word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 3'd0))
        else $error("result word with nothing in flight");

    // pipeline holds at most four words
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

    // gain never exceeds unity
    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.gain_now <= dmgm_pkg::GAIN_ONE))
        else $error("gain above unity");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=>
            (out_ch.valid && $stable(out_ch.out_sample) && $stable(out_ch.gain_now)))
        else $error("result word changed while stalled");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ducking_music_gain_mixer dmgm_checker u_dmgm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pready (pready),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

// ===== verif/tb_ducking_music_gain_mixer.sv =====
// tb_ducking_music_gain_mixer: self-checking bench for the ducking music gain mixer,
// a directed table then random phases of register settings and sample words, scored
// against the ramp model or typed results; depends on dmgm_pkg, dmgm_in_if, dmgm_out_if

module tb_ducking_music_gain_mixer;

    // unused status code, behaves as absent
    localparam logic [1:0] ST_UNUSED = 2'd3;
    // register index with nothing behind it
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    // pipeline depth plus margin, waited out after the last result
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 1100;
    localparam logic signed [dmgm_pkg::SAMPLE_W-1:0] SMP_MAX = 16'sh7fff;
    localparam logic signed [dmgm_pkg::SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [dmgm_pkg::SAMPLE_W-1:0] mix_sample;
        logic signed [dmgm_pkg::SAMPLE_W-1:0] music_sample;
        logic                                 duck;
        logic [1:0]                           music_status;
        logic                                 last_in_block;
    } sample_t;

    typedef struct packed {
        logic signed [dmgm_pkg::SAMPLE_W-1:0] out_sample;
        logic [dmgm_pkg::GAIN_W-1:0]          gain_now;
    } mixed_t;

    typedef enum logic [1:0] {
        ROW_REG,    // register write while idle
        ROW_WORD,   // sample word scored by the ramp model
        ROW_KNOWN   // sample word with its result typed in
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_sel;
        logic [31:0] wdata;
        sample_t     smp;
        mixed_t      want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [dmgm_pkg::APB_AW-1:0] paddr;
    logic [dmgm_pkg::APB_DW-1:0] pwdata;
    logic [dmgm_pkg::APB_DW-1:0] prdata;
    logic pready;

    dmgm_in_if  in_ch ();
    dmgm_out_if out_ch ();

    ducking_music_gain_mixer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // shadow of the block: register file and running music gain
    dmgm_pkg::cfg_t              shadow_cfg;
    logic [dmgm_pkg::GAIN_W-1:0] music_gain_track;

    mixed_t mixed_words_q [$];
    int     mismatches = 0;
    bit     sink_stalls_on = 1'b0;
    bit     src_gaps_on = 1'b0;
    stim_row_t directed_tbl [$];

    // gap or stall length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // ramp step and scaled music add, or hold or clear by status; advances the tracked gain
    function automatic mixed_t ramp_and_mix(sample_t s);
        mixed_t            res;
        int unsigned       g;
        int unsigned       target;
        int unsigned       up;
        longint unsigned   mag;
        longint unsigned   scaled;
        int                sum;
        int                music_i;
        g = music_gain_track;
        sum = s.mix_sample;
        music_i = s.music_sample;
        if (s.music_status == dmgm_pkg::ST_PRESENT)
        begin
            target = 0;
            if (shadow_cfg.music_enable)
            begin
                target = s.duck ? 32'(shadow_cfg.duck_gain) : 32'(shadow_cfg.base_gain);
                if (target > 32'(dmgm_pkg::GAIN_ONE))
                    target = 32'(dmgm_pkg::GAIN_ONE);
            end
            if (g < target)
            begin
                up = g + 32'(shadow_cfg.attack_step);
                g = (up > target) ? target : up;
            end
            else if (g > target)
            begin
                g = (g - target > 32'(shadow_cfg.release_step))
                    ? g - 32'(shadow_cfg.release_step) : target;
            end
            if (g != 0)
            begin
                mag = (music_i < 0) ? longint'(-music_i) : longint'(music_i);
                scaled = (mag * longint'(g) + 64'd8388608) >> 24;
                sum = (music_i < 0) ? sum - int'(scaled) : sum + int'(scaled);
                if (sum > 32767)
                    sum = 32767;
                if (sum < -32768)
                    sum = -32768;
            end
        end
        else if (s.music_status != dmgm_pkg::ST_WAITING)
        begin
            g = 0;
        end
        music_gain_track = g[dmgm_pkg::GAIN_W-1:0];
        res.out_sample = sum[dmgm_pkg::SAMPLE_W-1:0];
        res.gain_now   = music_gain_track;
        return res;
    endfunction

    // directed table helpers
    function automatic void reg_row(logic [2:0] sel, logic [31:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_sel = sel;
        r.wdata = data;
        directed_tbl = {directed_tbl, r};
    endfunction

    function automatic void word_row(int mix, int music, bit duck, logic [1:0] st, bit last);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.smp = '{mix[dmgm_pkg::SAMPLE_W-1:0], music[dmgm_pkg::SAMPLE_W-1:0], duck, st, last};
        directed_tbl = {directed_tbl, r};
    endfunction

    function automatic void known_row(int mix, int music, bit duck, logic [1:0] st, bit last,
                                      int out_smp, int gain);
        stim_row_t r;
        r = '0;
        r.kind = ROW_KNOWN;
        r.smp = '{mix[dmgm_pkg::SAMPLE_W-1:0], music[dmgm_pkg::SAMPLE_W-1:0], duck, st, last};
        r.want = '{out_smp[dmgm_pkg::SAMPLE_W-1:0], gain[dmgm_pkg::GAIN_W-1:0]};
        directed_tbl = {directed_tbl, r};
    endfunction

    // apb write: setup cycle, then access cycle; shadow follows
    task automatic write_reg(logic [2:0] sel, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            dmgm_pkg::REG_MUSIC_ENABLE: shadow_cfg.music_enable = data[0];
            dmgm_pkg::REG_BASE_GAIN:    shadow_cfg.base_gain    = data[dmgm_pkg::GAIN_W-1:0];
            dmgm_pkg::REG_DUCK_GAIN:    shadow_cfg.duck_gain    = data[dmgm_pkg::GAIN_W-1:0];
            dmgm_pkg::REG_ATTACK_STEP:  shadow_cfg.attack_step  = data[dmgm_pkg::STEP_W-1:0];
            dmgm_pkg::REG_RELEASE_STEP: shadow_cfg.release_step = data[dmgm_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    // send one sample word after a gap, queue its expected result on acceptance
    task automatic push_sample(sample_t s, int gap, bit typed, mixed_t typed_res);
        mixed_t res;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mix_sample    <= s.mix_sample;
        in_ch.music_sample  <= s.music_sample;
        in_ch.duck          <= s.duck;
        in_ch.music_status  <= s.music_status;
        in_ch.last_in_block <= s.last_in_block;
        do
            @(posedge clk);
        while (!in_ch.ready);
        res = ramp_and_mix(s);
        mixed_words_q = {mixed_words_q, (typed ? typed_res : res)};
    endtask

    // stop sending and wait for every expected word to come back
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (mixed_words_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic int src_gap();
        if (!src_gaps_on || $urandom_range(0, 99) < 55)
            return 0;
        return pick_gap();
    endfunction

    // sink side pacing of ready
    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (sink_stalls_on && $urandom_range(0, 99) < 30)
            begin
                out_ch.ready <= 1'b0;
                hold = pick_gap() - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // score each result word against the oldest expectation
    always @(posedge clk)
    begin
        mixed_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (mixed_words_q.size() == 0)
            begin
                $error("unexpected word: out_sample %0d gain_now %0d",
                       out_ch.out_sample, out_ch.gain_now);
                mismatches++;
            end
            else
            begin
                want = mixed_words_q.pop_front();
                if (out_ch.out_sample !== want.out_sample)
                begin
                    $error("out_sample: expected %0d, got %0d",
                           want.out_sample, out_ch.out_sample);
                    mismatches++;
                end
                if (out_ch.gain_now !== want.gain_now)
                begin
                    $error("gain_now: expected %0d, got %0d", want.gain_now, out_ch.gain_now);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #8000000;
        $display("ducking_music_gain_mixer regression: fail");
        $finish;
    end

    initial
    begin
        sample_t     s;
        mixed_t      none;
        int          sent;
        int          phase_len;
        int          roll;
        bit          steady;
        bit          first_phase;
        bit          duck_now;
        logic [31:0] data;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid         = 1'b0;
        in_ch.mix_sample    = '0;
        in_ch.music_sample  = '0;
        in_ch.duck          = 1'b0;
        in_ch.music_status  = dmgm_pkg::ST_PRESENT;
        in_ch.last_in_block = 1'b0;
        none = '0;

        shadow_cfg.music_enable = 1'b0;
        shadow_cfg.base_gain    = dmgm_pkg::BASE_GAIN_RST;
        shadow_cfg.duck_gain    = dmgm_pkg::DUCK_GAIN_RST;
        shadow_cfg.attack_step  = dmgm_pkg::ATTACK_STEP_RST;
        shadow_cfg.release_step = dmgm_pkg::RELEASE_STEP_RST;
        music_gain_track = '0;

        // directed table: defaults, extremes, status codes, ramp limits, rounding
        known_row(32767, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0, 32767, 0);
        known_row(-32768, -32768, 1'b1, dmgm_pkg::ST_PRESENT, 1'b1, -32768, 0);
        known_row(1234, -5, 1'b0, dmgm_pkg::ST_ABSENT, 1'b0, 1234, 0);
        known_row(-1, 77, 1'b1, ST_UNUSED, 1'b1, -1, 0);
        known_row(100, 32767, 1'b0, dmgm_pkg::ST_WAITING, 1'b0, 100, 0);
        reg_row(dmgm_pkg::REG_MUSIC_ENABLE, 32'd1);
        reg_row(dmgm_pkg::REG_BASE_GAIN, 32'd100000);
        reg_row(dmgm_pkg::REG_ATTACK_STEP, 32'd65535);
        word_row(0, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(0, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b1);
        word_row(32767, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(-32768, -32768, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        known_row(-300, 32767, 1'b0, dmgm_pkg::ST_WAITING, 1'b0, -300, 100000);
        // duck target above unity, slow release
        reg_row(dmgm_pkg::REG_DUCK_GAIN, 32'hffff_ffff);
        reg_row(dmgm_pkg::REG_RELEASE_STEP, 32'd1);
        word_row(10, -32768, 1'b1, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(10, 12345, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        reg_row(REG_UNMAPPED, 32'hffff_ffff);
        word_row(-20, 256, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        // disabled: fast ramp down to zero, then pass-through
        reg_row(dmgm_pkg::REG_MUSIC_ENABLE, 32'd0);
        reg_row(dmgm_pkg::REG_RELEASE_STEP, 32'd65535);
        word_row(0, 1000, 1'b1, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(0, -1000, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(0, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        known_row(-7, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b1, -7, 0);
        // half-way products round away from zero
        reg_row(dmgm_pkg::REG_MUSIC_ENABLE, 32'd1);
        reg_row(dmgm_pkg::REG_BASE_GAIN, 32'd32768);
        reg_row(dmgm_pkg::REG_ATTACK_STEP, 32'd32768);
        word_row(0, 256, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(0, -256, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(0, 255, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        word_row(5, -255, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0);
        known_row(99, 1, 1'b0, dmgm_pkg::ST_ABSENT, 1'b0, 99, 0);
        // zero attack keeps the gain at zero
        reg_row(dmgm_pkg::REG_ATTACK_STEP, 32'd0);
        known_row(3, 32767, 1'b0, dmgm_pkg::ST_PRESENT, 1'b0, 3, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        foreach (directed_tbl[i])
        begin
            if (directed_tbl[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(directed_tbl[i].reg_sel, directed_tbl[i].wdata);
            end
            else
            begin
                push_sample(directed_tbl[i].smp, src_gap(), directed_tbl[i].kind == ROW_KNOWN,
                            directed_tbl[i].want);
            end
        end

        // random phases: new register settings while idle, then a run of words
        sent = 0;
        first_phase = 1'b1;
        duck_now = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            drain_results();
            for (int r = dmgm_pkg::REG_MUSIC_ENABLE; r <= dmgm_pkg::REG_RELEASE_STEP; r++)
            begin
                if (first_phase || $urandom_range(0, 99) < 60)
                begin
                    roll = $urandom_range(0, 4);
                    data = $urandom();
                    case (r) inside
                        dmgm_pkg::REG_MUSIC_ENABLE:
                            data[0] = ($urandom_range(0, 99) < 85);
                        dmgm_pkg::REG_BASE_GAIN, dmgm_pkg::REG_DUCK_GAIN:
                            if (roll == 0)
                                data = 32'd0;
                            else if (roll == 1)
                                data = 32'(dmgm_pkg::GAIN_ONE);
                            else if (roll == 2)
                                data = 32'hffff_ffff;
                            else if (roll == 3)
                                data = $urandom_range(0, 32'(dmgm_pkg::GAIN_ONE));
                        default:
                            if (roll == 0)
                                data = 32'd0;
                            else if (roll == 1)
                                data = 32'd65535;
                            else if (roll == 2)
                                data = $urandom_range(1, 4096);
                    endcase
                    write_reg(r[2:0], data);
                end
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNMAPPED, $urandom());
            first_phase = 1'b0;

            steady = ($urandom_range(0, 5) == 0);
            phase_len = steady ? $urandom_range(200, 320) : $urandom_range(20, 80);
            src_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++)
            begin
                if ($urandom_range(0, 99) < 5)
                    duck_now = !duck_now;
                roll = $urandom_range(0, 99);
                s.mix_sample    = 16'($urandom());
                s.music_sample  = 16'($urandom());
                s.duck          = duck_now;
                s.last_in_block = 1'($urandom_range(0, 1));
                if (steady)
                    s.music_status = (roll < 95) ? dmgm_pkg::ST_PRESENT : dmgm_pkg::ST_WAITING;
                else if (roll < 84)
                    s.music_status = dmgm_pkg::ST_PRESENT;
                else if (roll < 92)
                    s.music_status = dmgm_pkg::ST_WAITING;
                else if (roll < 97)
                    s.music_status = dmgm_pkg::ST_ABSENT;
                else
                    s.music_status = ST_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    s.mix_sample = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                if ($urandom_range(0, 9) == 0)
                    s.music_sample = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                push_sample(s, src_gap(), 1'b0, none);
                sent++;
                // now and then the sender holds off until the pipeline has emptied
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("ducking_music_gain_mixer regression: pass");
        else
            $display("ducking_music_gain_mixer regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dmgm_pkg.sv
rtl/core/dmgm_in_if.sv
rtl/core/dmgm_out_if.sv
rtl/core/dmgm_gain_ramp.sv
rtl/core/ducking_music_gain_mixer.sv
rtl/core/dmgm_checker.sv
verif/tb_ducking_music_gain_mixer.sv
